/* rtl/tit_pkg.sv */
// ----------------------------------------------------------------------------
// Type intern table package
// Sizes, payload types and reset contents shared by the intern table files.
// ----------------------------------------------------------------------------
package tit_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_ARGS    = 8;
    localparam int ARG_LANES   = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HEAD_W      = 5;
    localparam int ARGS_W      = 8 * ARG_LANES;

    // Entries that exist right after reset: atomic, count one, arg0 = index.
    localparam int BOOT_ENTRIES = 3;
    localparam logic [HEAD_W-1:0] BOOT_HEAD = 5'b0_0001;

    // One descriptor to look up or insert.
    typedef struct packed {
        logic       kind;
        logic [3:0] arg_count;
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic [7:0] arg2;
        logic [7:0] arg3;
        logic [7:0] arg4;
        logic [7:0] arg5;
        logic [7:0] arg6;
        logic [7:0] arg7;
    } t_req;

    // Result of one lookup.
    typedef struct packed {
        logic [7:0] index;
        logic       inserted;
        logic       full_res;
    } t_rsp;

endpackage

/* rtl/tit_req_if.sv */
// ----------------------------------------------------------------------------
// Intern table request channel
// Valid/ready channel that carries one descriptor per transfer.
// ----------------------------------------------------------------------------
interface tit_req_if;
    logic          valid;
    logic          ready;
    tit_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tit_rsp_if.sv */
// ----------------------------------------------------------------------------
// Intern table response channel
// Valid/ready channel that carries one lookup result per transfer.
// ----------------------------------------------------------------------------
interface tit_rsp_if;
    logic          valid;
    logic          ready;
    tit_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/type_intern_table.sv */
// ----------------------------------------------------------------------------
// Type intern table
// Lookup-or-insert table of type descriptors with a linear search sequencer.
// ----------------------------------------------------------------------------
// The block takes one descriptor at a time and scans the stored entries from
// index 0 upward, one entry per clock through a single registered-read port of
// the entry memory and one shared comparator. The first match is returned; if
// none matches, the descriptor is appended at the next free index, or, with
// all TABLE_DEPTH entries used, full_res is raised and nothing is stored. The
// scan covers the N stored entries (3 after reset, at most TABLE_DEPTH); an
// early match ends it sooner. The next request is taken in the cycle after the
// result is handed off. A finished result waits in an output register, and the
// next request is taken while it waits. Entries 0 to 2 are built in after
// reset.
// ----------------------------------------------------------------------------
module type_intern_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tit_req_if.sink   i_req,
    tit_rsp_if.source o_rsp
);
    import tit_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FIN    = 2'd2;

    // Entry memory: head in the upper bits, packed arguments below.
    logic [HEAD_W+ARGS_W-1:0] mem [TABLE_DEPTH];
    logic [HEAD_W+ARGS_W-1:0] r_rd;
    logic                     mem_we;

    logic [1:0]        r_state,   n_state;
    logic [CNT_W-1:0]  r_addr,    n_addr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [HEAD_W-1:0] r_head,    n_head;
    logic [ARGS_W-1:0] r_args,    n_args;
    logic [CNT_W-1:0]  r_count,   n_count;
    t_rsp              r_res,     n_res;
    t_rsp              r_out,     n_out;
    logic              r_out_vld, n_out_vld;

    logic              out_free;
    logic [HEAD_W-1:0] ent_head;
    logic [ARGS_W-1:0] ent_args;
    logic              hit;
    logic              last;
    logic              table_full;

    // The built-in entries are supplied by logic instead of the memory.
    always_comb begin
        if (r_cmp_idx < IDX_W'(BOOT_ENTRIES)) begin
            ent_head = BOOT_HEAD;
            ent_args = ARGS_W'(r_cmp_idx);
        end else begin
            ent_head = r_rd[HEAD_W+ARGS_W-1:ARGS_W];
            ent_args = r_rd[ARGS_W-1:0];
        end
    end

    // Shared comparator: head must be equal, and each argument lane below the
    // count (limited to MAX_ARGS) must be equal.
    always_comb begin
        logic lanes_ok;
        lanes_ok = 1'b1;
        for (int i = 0; i < ARG_LANES; i++) begin
            if ((4'(i) < r_head[3:0]) && (i < MAX_ARGS)) begin
                if (ent_args[8*i +: 8] != r_args[8*i +: 8]) begin
                    lanes_ok = 1'b0;
                end
            end
        end
        hit = (ent_head == r_head) && lanes_ok;
    end

    assign last       = (CNT_W'(r_cmp_idx) == (r_count - CNT_W'(1)));
    assign table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign out_free   = !r_out_vld || o_rsp.ready;

    // Sequencer: capture, scan through the registered read port, then hand off.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_addr[IDX_W-1:0];
        n_head    = r_head;
        n_args    = r_args;
        n_count   = r_count;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        mem_we    = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_head  = {i_req.data.kind, i_req.data.arg_count};
                    n_args  = {i_req.data.arg7, i_req.data.arg6, i_req.data.arg5,
                               i_req.data.arg4, i_req.data.arg3, i_req.data.arg2,
                               i_req.data.arg1, i_req.data.arg0};
                    n_addr  = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_addr < r_count) begin
                    n_addr    = r_addr + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end
                if (r_cmp_vld) begin
                    if (hit) begin
                        n_res.index    = 8'(r_cmp_idx);
                        n_res.inserted = 1'b0;
                        n_res.full_res = 1'b0;
                        n_state        = S_FIN;
                    end else if (last) begin
                        n_res.index    = table_full ? 8'd0 : 8'(r_count[IDX_W-1:0]);
                        n_res.inserted = !table_full;
                        n_res.full_res = table_full;
                        n_state        = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    if (r_res.inserted) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_count   <= CNT_W'(BOOT_ENTRIES);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
        r_addr    <= n_addr;
        r_cmp_idx <= n_cmp_idx;
        r_head    <= n_head;
        r_args    <= n_args;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // Entry memory: append port and registered scan read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= {r_head, r_args};
        end
        r_rd <= mem[r_addr[IDX_W-1:0]];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // The fill count stays between the built-in entries and the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(BOOT_ENTRIES)) && (r_count <= CNT_W'(TABLE_DEPTH)))
        else $error("entry count out of range");

    // A result never claims both an insert and a full table.
    a_rsp_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.data.inserted && o_rsp.data.full_res))
        else $error("result both inserted and full");

    // An insert handed off bumps the fill count by exactly one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free && r_res.inserted)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance entry count");

    // A new result is loaded only when leaving the hand-off state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_vld && n_out_vld) |-> (r_state == S_FIN))
        else $error("result loaded outside hand-off");

    // The compare stage only sees entries below the fill count.
    a_cmp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (CNT_W'(r_cmp_idx) < r_count))
        else $error("compare beyond stored entries");

endmodule

/* test/type_intern_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Type intern table testbench
// Drives descriptors into the intern table and checks every lookup result
// against a predicted copy of the table. A directed set covers the boot
// entries, counts of zero and above eight, ignored trailing arguments and
// near misses. Random traffic then repeats, perturbs and invents descriptors
// until the table fills and reports full, under changing backpressure.
// ----------------------------------------------------------------------------
module type_intern_table_tb;
    import tit_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 2000;
    localparam int RANDOM_ITEMS = 1525;

    // Predicted table contents and the queue of results still to arrive.
    class intern_checker;
        logic [HEAD_W-1:0] heads [TABLE_DEPTH];
        logic [ARGS_W-1:0] lanes [TABLE_DEPTH];
        int unsigned       stored;
        t_rsp              awaited_rsp [$];
        int unsigned       errors;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                heads[i] = '0;
                lanes[i] = '0;
            end
            for (int i = 0; i < BOOT_ENTRIES; i++) begin
                heads[i] = BOOT_HEAD;
                lanes[i] = ARGS_W'(i);
            end
            stored = BOOT_ENTRIES;
            errors = 0;
        endfunction

        // Look the descriptor up in the predicted table, append on a miss.
        function void note_descriptor(t_req d);
            logic [HEAD_W-1:0] head;
            logic [ARGS_W-1:0] args;
            int                lim;
            bit                same;
            t_rsp              r;
            head = {d.kind, d.arg_count};
            args = {d.arg7, d.arg6, d.arg5, d.arg4, d.arg3, d.arg2, d.arg1, d.arg0};
            lim  = (d.arg_count > MAX_ARGS) ? MAX_ARGS : d.arg_count;
            for (int i = 0; i < stored; i++) begin
                if (heads[i] == head) begin
                    same = 1'b1;
                    for (int k = 0; k < lim; k++) begin
                        if (args[8*k +: 8] != lanes[i][8*k +: 8]) same = 1'b0;
                    end
                    if (same) begin
                        r.index    = 8'(i);
                        r.inserted = 1'b0;
                        r.full_res = 1'b0;
                        awaited_rsp.push_back(r);
                        return;
                    end
                end
            end
            if (stored >= TABLE_DEPTH) begin
                r.index    = '0;
                r.inserted = 1'b0;
                r.full_res = 1'b1;
            end else begin
                heads[stored] = head;
                lanes[stored] = args;
                r.index    = 8'(stored);
                r.inserted = 1'b1;
                r.full_res = 1'b0;
                stored++;
            end
            awaited_rsp.push_back(r);
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                $display("%0t: result without a pending lookup: index %0d inserted %0b full %0b",
                         $time, got.index, got.inserted, got.full_res);
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.index !== want.index) begin
                $display("%0t: index mismatch, expected %0d, actual %0d",
                         $time, want.index, got.index);
                errors++;
            end
            if (got.inserted !== want.inserted) begin
                $display("%0t: inserted mismatch, expected %0b, actual %0b",
                         $time, want.inserted, got.inserted);
                errors++;
            end
            if (got.full_res !== want.full_res) begin
                $display("%0t: full_res mismatch, expected %0b, actual %0b",
                         $time, want.full_res, got.full_res);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    tit_req_if     req_ch ();
    tit_rsp_if     rsp_ch ();
    intern_checker board;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks     = 0;
    int          hold_done     = 0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;
    t_req        sent_log [$];

    type_intern_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Clock.
    always #HALF_PERIOD i_clk = ~i_clk;

    // Receiver: random ready, with a long hold-off each time one is asked for.
    always @(posedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor both channels and feed the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) board.note_descriptor(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) board.check_result(rsp_ch.data);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_req make_desc(input logic kind, input logic [3:0] count,
                                       input logic [ARGS_W-1:0] args);
        t_req d;
        d.kind      = kind;
        d.arg_count = count;
        {d.arg7, d.arg6, d.arg5, d.arg4, d.arg3, d.arg2, d.arg1, d.arg0} = args;
        return d;
    endfunction

    // Random descriptor: mostly repeats with changed trailing arguments,
    // some near misses of earlier ones and some fresh descriptors.
    function automatic t_req random_descriptor();
        t_req              d;
        int                pick;
        int                lim;
        logic [ARGS_W-1:0] args;
        logic [ARGS_W-1:0] junk;
        pick = $urandom_range(99);
        junk = {$urandom, $urandom};
        if (pick < 22 || sent_log.size() == 0) begin
            d = make_desc(1'($urandom_range(1)),
                          ($urandom_range(15) == 0) ? 4'($urandom_range(15, 9))
                                                    : 4'($urandom_range(8)),
                          junk);
            return d;
        end
        d    = sent_log[$urandom_range(sent_log.size() - 1)];
        args = {d.arg7, d.arg6, d.arg5, d.arg4, d.arg3, d.arg2, d.arg1, d.arg0};
        lim  = (d.arg_count > MAX_ARGS) ? MAX_ARGS : d.arg_count;
        if (pick < 32) begin
            case ($urandom_range(2))
                0: d.kind = ~d.kind;
                1: d.arg_count = d.arg_count + 4'd1;
                default: begin
                    if (lim == 0) d.kind = ~d.kind;
                    else args[8*$urandom_range(lim - 1) +: 8] = 8'($urandom);
                end
            endcase
        end else begin
            // Arguments past the count never take part in the match.
            for (int k = lim; k < ARG_LANES; k++) args[8*k +: 8] = junk[8*k +: 8];
        end
        {d.arg7, d.arg6, d.arg5, d.arg4, d.arg3, d.arg2, d.arg1, d.arg0} = args;
        return d;
    endfunction

    // Offer one descriptor, with random idle cycles ahead of it.
    task automatic send_item(input t_req d);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= d;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_log.push_back(d);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req directed [$];
        board        = new();
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        for (int i = 0; i < BOOT_ENTRIES; i++) begin
            sent_log.push_back(make_desc(1'b0, 4'd1, ARGS_W'(i)));
        end

        // Boot entries, count zero, full lanes, counts above eight, prefixes.
        directed.push_back(make_desc(1'b0, 4'd1,  64'h0));
        directed.push_back(make_desc(1'b0, 4'd1,  64'hFFFF_FFFF_FFFF_FF02));
        directed.push_back(make_desc(1'b1, 4'd1,  64'h1));
        directed.push_back(make_desc(1'b0, 4'd0,  64'h0));
        directed.push_back(make_desc(1'b0, 4'd0,  64'hA5A5_A5A5_A5A5_A5A5));
        directed.push_back(make_desc(1'b1, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_desc(1'b1, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_desc(1'b1, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_desc(1'b1, 4'd8,  64'h7FFF_FFFF_FFFF_FFFF));
        directed.push_back(make_desc(1'b0, 4'd8,  64'h0));
        directed.push_back(make_desc(1'b1, 4'd15, 64'h0123_4567_89AB_CDEF));
        directed.push_back(make_desc(1'b1, 4'd15, 64'h0123_4567_89AB_CDEF));
        directed.push_back(make_desc(1'b1, 4'd9,  64'h0123_4567_89AB_CDEF));
        directed.push_back(make_desc(1'b1, 4'd8,  64'h0123_4567_89AB_CDEF));
        directed.push_back(make_desc(1'b1, 4'd3,  64'h0000_0000_00FF_FFFF));
        directed.push_back(make_desc(1'b0, 4'd1,  64'hFF));
        directed.push_back(make_desc(1'b1, 4'd2,  64'hAAAA));
        directed.push_back(make_desc(1'b1, 4'd2,  64'h5555));
        directed.push_back(make_desc(1'b0, 4'd4,  64'h5555_AAAA_5555_AAAA));
        directed.push_back(make_desc(1'b1, 4'd1,  64'h1));
        directed.push_back(make_desc(1'b0, 4'd1,  64'h1));
        directed.push_back(make_desc(1'b1, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_desc(1'b0, 4'd7,  64'h005A_5A5A_5A5A_5A5A));
        directed.push_back(make_desc(1'b0, 4'd7,  64'hC35A_5A5A_5A5A_5A5A));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_item(directed[i]);
        wait_drained();

        // Three random phases with different backpressure on each side.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // The receiver stalls for a long stretch while items
                    // keep coming, so the block backs up to its input.
                    hold_asks <= hold_asks + 1;
                end
            endcase
            repeat (RANDOM_ITEMS / 3) send_item(random_descriptor());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending());
        end
        if (board.errors == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
